// ===== hdl/fpa_pkg.sv =====
`default_nettype none

package fpa_pkg;

  localparam int unsigned MAX_PAGES  = 1024;
  localparam int unsigned PAGE_SPACE = 1024;
  localparam int unsigned PAGE_W     = 10;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STATUS_W   = 2;

  // Page numbers are 10 bits wide, so the store never holds more than PAGE_SPACE pages.
  localparam logic [COUNT_W-1:0] CAPACITY =
    COUNT_W'((MAX_PAGES < PAGE_SPACE) ? MAX_PAGES : PAGE_SPACE);

  localparam logic [OP_W-1:0] OP_ALLOC    = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE     = 2'd1;
  localparam logic [OP_W-1:0] OP_SET_ROOT = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP      = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [PAGE_W-1:0] page_num;
  } fpa_in_t;

  typedef struct packed {
    logic [PAGE_W-1:0]   alloc_page;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   root_page;
    logic [COUNT_W-1:0]  page_count;
  } fpa_out_t;

endpackage

`default_nettype wire

// ===== hdl/fpa_ram.sv =====
`default_nettype none

module fpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire  [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire  [WIDTH-1:0]          wdata_i,
  input  wire                       re_i,
  input  wire  [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/free_list_page_allocator_top.sv =====
// Page allocator with a LIFO free list linked through a next-pointer memory.
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one command beat:
// allocate, free a page, set the root page, or no operation.
// Output channel (out_valid_o / out_ready_i / out_data_o) returns exactly one
// result beat per command: allocated page, status, root page and page count.
// Timing: a result is registered and shows in the cycle after its command beat;
// an allocate that pops the free list first reads the popped page's link from
// the synchronous next-pointer memory and registers its result after that.
// Throughput: one command every cycle for free, set-root, no-op and allocate
// from never-used pages while results drain; a pop holds off the next command.
// The block works on one command at a time; a new beat is taken while the
// previous result is handed over in the same cycle.
// Reset: free list empty, page count 1 (header page only), root page 0.
// The link memory is not cleared; only entries written by a free are read.
// Stall: while the receiver holds out_ready_i low, the result register holds
// its beat and no new command is accepted.
`default_nettype none

module free_list_page_allocator_top
  import fpa_pkg::*;
(
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           in_valid_i,
  output logic          in_ready_o,
  input  wire fpa_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire           out_ready_i,
  output fpa_out_t      out_data_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_POP  = 1'b1;

  logic              state_q, state_d;
  logic [PAGE_W-1:0] head_q, head_d;
  logic [COUNT_W-1:0] pages_q, pages_d;
  logic [PAGE_W-1:0] root_q, root_d;
  logic              out_valid_q, out_valid_d;
  fpa_out_t          out_q, out_d;

  logic              mem_we, mem_re;
  logic [PAGE_W-1:0] mem_waddr, mem_wdata, mem_rdata;
  logic              in_beat;

  // Accept only when idle and the result register is empty or being drained.
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_beat    = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    pages_d     = pages_q;
    root_d      = root_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = in_data_i.page_num;
    mem_wdata   = head_q;
    mem_re      = 1'b0;

    // Drop the result once the receiver takes it.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_POP: begin
        // Link of the popped page is back: advance the head, emit the page.
        head_d           = mem_rdata;
        out_d.alloc_page = head_q;
        out_d.status     = STATUS_OK;
        out_d.root_page  = root_q;
        out_d.page_count = pages_q;
        out_valid_d      = 1'b1;
        state_d          = ST_IDLE;
      end
      default: begin
        if (in_beat) begin
          out_d.alloc_page = '0;
          out_d.status     = STATUS_OK;
          out_valid_d      = 1'b1;
          case (in_data_i.op)
            OP_ALLOC: begin
              if (head_q != '0) begin
                // Pop: fetch the link first; the result is formed in ST_POP.
                mem_re      = 1'b1;
                out_valid_d = 1'b0;
                state_d     = ST_POP;
              end else if (pages_q < CAPACITY) begin
                out_d.alloc_page = pages_q[PAGE_W-1:0];
                pages_d          = pages_q + COUNT_W'(1);
              end else begin
                out_d.status = STATUS_FULL;
              end
            end
            OP_FREE: begin
              if (in_data_i.page_num == '0 ||
                  {1'b0, in_data_i.page_num} >= pages_q) begin
                out_d.status = STATUS_INVALID;
              end else begin
                // Push: link the freed page to the old head.
                mem_we = 1'b1;
                head_d = in_data_i.page_num;
              end
            end
            OP_SET_ROOT: begin
              root_d = in_data_i.page_num;
            end
            default: begin
            end
          endcase
          out_d.root_page  = root_d;
          out_d.page_count = pages_d;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      pages_q     <= COUNT_W'(1);
      root_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      pages_q     <= pages_d;
      root_q      <= root_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  fpa_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (PAGE_SPACE)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (head_q),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== hdl/fpa_checker.sv =====
`default_nettype none

module fpa_checker
  import fpa_pkg::*;
(
  input wire           clk_i,
  input wire           rst_ni,
  input wire           in_valid_i,
  input wire           in_ready_o,
  input wire fpa_in_t  in_data_i,
  input wire           out_valid_o,
  input wire           out_ready_i,
  input wire fpa_out_t out_data_o
);

  // Hold a stalled result beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // A failed command never hands out a page.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != STATUS_OK |-> out_data_o.alloc_page == '0)
    else $error("page handed out with error status");

  // Any page handed out was created before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.alloc_page != '0 |->
      {1'b0, out_data_o.alloc_page} < out_data_o.page_count &&
      out_data_o.page_count <= CAPACITY)
    else $error("allocated page beyond page count");

endmodule

bind free_list_page_allocator_top fpa_checker u_fpa_checker (.*);

`default_nettype wire

// ===== test/free_list_page_allocator_top_tb.sv =====
`timescale 1ns / 100ps

module free_list_page_allocator_top_tb
  import fpa_pkg::*;
;

  localparam int unsigned STALL_LIMIT  = 1000; // cycles with no beat on either side
  localparam int unsigned DRAIN_CYCLES = 20;   // quiet time after the last result

  // Receiver ready patterns; each one holds for a random stretch of cycles.
  typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE, RX_HOLD} rx_pattern_e;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  fpa_in_t  in_data_i   = '0;
  logic     out_ready_i = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  fpa_out_t out_data_o;

  free_list_page_allocator_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Allocator shadow: link memory, list head, pages made and root, updated once
  // per accepted command beat. Links that were never written are never read.
  // ---------------------------------------------------------------------------
  bit [PAGE_W-1:0]  link_mem [PAGE_SPACE];
  bit [PAGE_W-1:0]  list_head  = '0;
  bit [COUNT_W-1:0] made_count = COUNT_W'(1);
  bit [PAGE_W-1:0]  root_now   = '0;

  fpa_in_t  cmd_backlog [$];  // command beats waiting for the driver
  fpa_out_t due_results [$];  // predicted result beats, oldest first

  int unsigned n_errors  = 0;
  int unsigned n_sent    = 0;
  int unsigned n_checked = 0;
  int unsigned n_fresh   = 0;
  int unsigned n_pops    = 0;
  int unsigned n_full    = 0;
  int unsigned n_reject  = 0;

  function automatic fpa_out_t predict_outcome(input fpa_in_t cmd);
    fpa_out_t res;
    res = '0;
    case (cmd.op)
      OP_ALLOC: begin
        if (list_head != '0) begin
          // Pop the head; its link names the next free page.
          res.alloc_page = list_head;
          list_head      = link_mem[list_head];
          n_pops++;
        end else if (made_count < CAPACITY) begin
          res.alloc_page = made_count[PAGE_W-1:0];
          made_count     = made_count + COUNT_W'(1);
          n_fresh++;
        end else begin
          res.status = STATUS_FULL;
          n_full++;
        end
      end
      OP_FREE: begin
        // Header page and pages never created are rejected untouched.
        if (cmd.page_num == '0 || {1'b0, cmd.page_num} >= made_count) begin
          res.status = STATUS_INVALID;
          n_reject++;
        end else begin
          link_mem[cmd.page_num] = list_head;
          list_head              = cmd.page_num;
        end
      end
      OP_SET_ROOT: root_now = cmd.page_num;
      default: ;
    endcase
    res.root_page  = root_now;
    res.page_count = made_count;
    return res;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR result %0d: %s", n_checked, msg);
    n_errors++;
  endtask

  task automatic check_result(input fpa_out_t got, input fpa_out_t want);
    if (got.alloc_page !== want.alloc_page)
      flag_error($sformatf("alloc_page %0d, want %0d", got.alloc_page, want.alloc_page));
    if (got.status !== want.status)
      flag_error($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.root_page !== want.root_page)
      flag_error($sformatf("root_page %0d, want %0d", got.root_page, want.root_page));
    if (got.page_count !== want.page_count)
      flag_error($sformatf("page_count %0d, want %0d", got.page_count, want.page_count));
    n_checked++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus planning. A light tracker of live pages and the free stack lets the
  // random part free only pages that are really handed out, so the list stays
  // well formed until the store has filled; double frees come at the very end,
  // since they can leave the list looping for good.
  // ---------------------------------------------------------------------------
  int unsigned plan_made = 1;
  int unsigned plan_live  [$];
  int unsigned plan_stack [$];

  task automatic queue_cmd(input logic [OP_W-1:0] op, input int unsigned pg);
    fpa_in_t cmd;
    cmd.op       = op;
    cmd.page_num = pg[PAGE_W-1:0];
    cmd_backlog.push_back(cmd);
  endtask

  task automatic plan_alloc();
    // The page field is ignored on allocate; fill it with noise.
    queue_cmd(OP_ALLOC, $urandom_range(0, PAGE_SPACE - 1));
    if (plan_stack.size() != 0) begin
      plan_live.push_back(plan_stack.pop_back());
    end else if (plan_made < int'(CAPACITY)) begin
      plan_live.push_back(plan_made);
      plan_made++;
    end
  endtask

  task automatic plan_free_page(input int unsigned pg);
    queue_cmd(OP_FREE, pg);
    foreach (plan_live[k]) begin
      if (plan_live[k] == pg) begin
        plan_live.delete(k);
        plan_stack.push_back(pg);
        break;
      end
    end
  endtask

  task automatic plan_free_live();
    if (plan_live.size() == 0) plan_free_page(0);
    else plan_free_page(plan_live[$urandom_range(0, plan_live.size() - 1)]);
  endtask

  task automatic plan_bad_free();
    if (plan_made >= int'(CAPACITY) || $urandom_range(0, 1) == 0) queue_cmd(OP_FREE, 0);
    else queue_cmd(OP_FREE, $urandom_range(plan_made, PAGE_SPACE - 1));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps. Hold valid and the beat
  // until accepted; predict the outcome at the edge the beat is taken.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        due_results.push_back(predict_outcome(in_data_i));
        n_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (cmd_backlog.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= cmd_backlog.pop_front();
          if (burst_left <= 1) begin
            // Start a new burst; a quarter of them follow with no gap at all.
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted result beat against the oldest prediction and
  // advance the receiver's own ready pattern.
  // ---------------------------------------------------------------------------
  rx_pattern_e rx_pattern = RX_STREAM;
  int unsigned rx_left    = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_pattern  <= RX_STREAM;
      rx_left     <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (due_results.size() == 0) flag_error("result beat with no command outstanding");
        else check_result(out_data_o, due_results.pop_front());
      end
      if (rx_left == 0) begin
        rx_left    <= $urandom_range(5, 60);
        rx_pattern <= rx_pattern_e'($urandom_range(0, 3));
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_pattern)
        RX_STREAM: out_ready_i <= 1'b1;
        RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
        default:   out_ready_i <= 1'b0;
      endcase
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("TIMEOUT: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Build the command list, release reset, then wait for the block to drain.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned pick;
    int unsigned lean;
    int unsigned alloc_pct;
    int unsigned pg;

    // Directed: root extremes, no-op, rejected frees, fresh pages, list pops
    // back to back, freeing the page right at the page count, uncreated root.
    queue_cmd(OP_SET_ROOT, PAGE_SPACE - 1);
    queue_cmd(OP_SET_ROOT, 0);
    queue_cmd(OP_NOP, PAGE_SPACE - 1);
    plan_free_page(0);
    plan_free_page(1);               // nothing created yet
    plan_free_page(PAGE_SPACE - 1);
    repeat (3) plan_alloc();         // pages 1, 2, 3
    plan_free_page(2);
    plan_free_page(3);
    plan_free_page(4);               // equals the page count: rejected
    repeat (3) plan_alloc();         // pop 3, pop 2, then fresh page 4
    plan_free_page(1);
    repeat (2) plan_alloc();         // pop 1, then fresh page 5
    queue_cmd(OP_SET_ROOT, 5);
    queue_cmd(OP_SET_ROOT, 700);     // root on an uncreated page
    queue_cmd(OP_NOP, 0);

    // Mixed traffic: stretches lean toward allocating or freeing so the list
    // grows deep and drains again.
    for (int i = 0; i < 200; i++) begin
      if (i % 16 == 0) lean = $urandom_range(0, 2);
      alloc_pct = (lean == 0) ? 70 : (lean == 1) ? 25 : 45;
      pick = $urandom_range(0, 99);
      if (pick < alloc_pct) plan_alloc();
      else if (pick < 88) plan_free_live();
      else if (pick < 92) plan_bad_free();
      else if (pick < 97) queue_cmd(OP_SET_ROOT, $urandom_range(0, PAGE_SPACE - 1));
      else queue_cmd(OP_NOP, $urandom_range(0, PAGE_SPACE - 1));
    end

    // Fill the store: mostly allocates until every page exists and none is free.
    while (plan_made < int'(CAPACITY) || plan_stack.size() != 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 90) plan_alloc();
      else if (pick < 94) plan_free_live();
      else if (pick < 97) queue_cmd(OP_SET_ROOT, $urandom_range(0, PAGE_SPACE - 1));
      else plan_bad_free();
    end
    repeat (12) plan_alloc();        // store full

    // Churn at capacity: pops, full allocates once the list empties again.
    for (int i = 0; i < 100; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) plan_alloc();
      else if (pick < 85) plan_free_live();
      else if (pick < 90) plan_bad_free();
      else if (pick < 95) queue_cmd(OP_SET_ROOT, $urandom_range(0, PAGE_SPACE - 1));
      else queue_cmd(OP_NOP, $urandom_range(0, PAGE_SPACE - 1));
    end

    // Double frees last, followed by unplanned noise on a list that may loop.
    for (int r = 0; r < 3; r++) begin
      pg = (plan_live.size() != 0) ? plan_live[0] : 1;
      queue_cmd(OP_FREE, pg);
      queue_cmd(OP_FREE, pg);
      for (int i = 0; i < 10; i++)
        queue_cmd(OP_W'($urandom_range(0, 3)), $urandom_range(0, PAGE_SPACE - 1));
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0 || in_valid_i) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (due_results.size() != 0) flag_error("results still outstanding at end of run");

    $display("Run: %0d commands sent, %0d results checked, %0d pages in store at end.",
             n_sent, n_checked, made_count);
    $display("Allocates: %0d fresh, %0d from the free list, %0d full; %0d frees rejected.",
             n_fresh, n_pops, n_full, n_reject);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/fpa_pkg.sv
hdl/fpa_ram.sv
hdl/free_list_page_allocator_top.sv
hdl/fpa_checker.sv
test/free_list_page_allocator_top_tb.sv
